// ===== rtl/icpid_pkg.sv =====
// Shared widths, reset values, register codes and divide constants for the PID block.
package icpid_pkg;

  // Widths of the external fields and of the configuration port.
  localparam int unsigned POS_W   = 16;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned CFG_D_W = 16;

  // Internal arithmetic widths.
  localparam int unsigned ERR_W   = 18;  // setpoint minus measurement and first difference
  localparam int unsigned DD_W    = 19;  // second difference
  localparam int unsigned SUM_W   = 36;  // sum of the three gain products
  localparam int unsigned MAG_W   = 35;  // magnitude of that sum
  localparam int unsigned QUO_W   = 32;  // magnitude of the increment
  localparam int unsigned INC_W   = 33;  // signed increment
  localparam int unsigned NXT_W   = 34;  // drive plus increment before the clamp

  // Reset values of the drive limits.
  localparam logic [POS_W-1:0] DRIVE_MAX_RESET = 16'd1900;
  localparam logic [POS_W-1:0] DRIVE_MIN_RESET = 16'd1800;

  // Division by ten of the sum magnitude x = xh * 2^16 + xl:
  //   x / 10 = xh * 6553 + (6 * xh + xl) / 10, since 2^16 = 10 * 6553 + 6.
  // The low part stays below 2^22 and is divided by a reciprocal multiply.
  localparam int unsigned SPLIT_W   = 16;
  localparam int unsigned XH_W      = MAG_W - SPLIT_W;
  localparam int unsigned LOW_W     = 22;
  localparam int unsigned QLO_W     = 19;
  localparam logic [31:0] DIV_HI_MUL = 32'd6553;
  localparam logic [LOW_W-1:0] DIV_LO_MUL = 22'd6;
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // Configuration register indexes.
  typedef enum logic [CFG_A_W-1:0] {
    REG_SETPOINT  = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_DRIVE_MAX = 3'd4,
    REG_DRIVE_MIN = 3'd5
  } cfg_reg_e;

endpackage

// ===== rtl/icpid_if.sv =====
// Handshake interfaces for the measurement, drive and configuration channels.
interface icpid_meas_if;
  logic                         valid;
  logic                         ready;
  logic [icpid_pkg::POS_W-1:0]  measured_position;

  modport source (output valid, output measured_position, input ready);
  modport sink   (input valid, input measured_position, output ready);
endinterface

interface icpid_drive_if;
  logic                         valid;
  logic                         ready;
  logic [icpid_pkg::POS_W-1:0]  drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

interface icpid_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [icpid_pkg::CFG_A_W-1:0] index;
  logic [icpid_pkg::CFG_D_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/incremental_pid_clamped.sv =====
// Incremental PID position controller with a clamped drive output.
//
// Usage: each request on meas_i carries one measured position. The block forms
// the error against the setpoint, keeps the two previous errors and the drive
// level, adds (kp*(e-e1) + ki*e + kd*(e-2*e1+e2)) / 10 to the drive, clamps
// it to [drive_min, drive_max] and sends the new drive as one request on
// drive_o. Gains are in tenths; the divide truncates toward zero.
// cfg_i writes the six registers (setpoint, three gains, two limits) and is
// always ready; writes to indexes six and seven are dropped. Write it only
// while no measurement is in flight.
// Path: an accepted measurement passes the stages input, error, products,
// sum, divide split, increment and output before it shows as a valid drive.
// Throughput: one measurement per cycle while drive_o is ready. Stages fill
// bubbles on their own, so a request is still taken while a finished drive waits.
// Stall: when drive_o is held off, the output register keeps its value and
// the stages behind it fill up; meas_i.ready drops only once all are full.
// Reset: gains and setpoint clear, the limits return to 1900 and 1800, the
// error history and the drive level clear, and the pipeline empties.
module incremental_pid_clamped (
  input  logic        clk_i,
  input  logic        rst_ni,
  icpid_meas_if.sink    meas_i,
  icpid_drive_if.source drive_o,
  icpid_cfg_if.sink     cfg_i
);

  localparam int unsigned NUM_STG = 6;

  // Configuration registers.
  logic [icpid_pkg::POS_W-1:0] setpoint_q, gain_p_q, gain_i_q, gain_d_q;
  logic [icpid_pkg::POS_W-1:0] drive_max_q, drive_min_q;

  // Pipeline control: valid per stage and the load enable of each stage.
  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG-1:0] load;
  logic               load_out;
  logic               out_valid_q;

  // Error history and drive level.
  logic signed [icpid_pkg::ERR_W-1:0] last_err_q, prior_err_q;
  logic [icpid_pkg::POS_W-1:0]        drive_q;

  // Stage payloads.
  logic [icpid_pkg::POS_W-1:0]        meas0_q;
  logic signed [icpid_pkg::ERR_W-1:0] err1_q, dp1_q;
  logic signed [icpid_pkg::DD_W-1:0]  dd1_q;
  logic signed [icpid_pkg::SUM_W-1:0] prod_p2_q, prod_i2_q, prod_d2_q;
  logic [icpid_pkg::MAG_W-1:0]        mag3_q;
  logic                               neg3_q;
  logic [icpid_pkg::QUO_W-1:0]        hi4_q;
  logic [icpid_pkg::QLO_W-1:0]        qlo4_q;
  logic                               neg4_q;
  logic signed [icpid_pkg::INC_W-1:0] inc5_q;

  // Combinational values of each stage.
  logic signed [icpid_pkg::ERR_W-1:0] err_d, dp_d;
  logic signed [icpid_pkg::DD_W-1:0]  dd_d;
  logic signed [34:0]                 prod_p_d, prod_i_d;
  logic signed [35:0]                 prod_d_d;
  logic signed [icpid_pkg::SUM_W-1:0] sum_d;
  logic [icpid_pkg::MAG_W-1:0]        mag_d;
  logic [icpid_pkg::XH_W-1:0]         xh;
  logic [icpid_pkg::SPLIT_W-1:0]      xl;
  logic [icpid_pkg::LOW_W-1:0]        low_d;
  logic [63:0]                        recip_prod;
  logic [icpid_pkg::QUO_W-1:0]        hi_d;
  logic [icpid_pkg::QUO_W-1:0]        quo_d;
  logic signed [icpid_pkg::INC_W-1:0] inc_d;
  logic signed [icpid_pkg::NXT_W-1:0] next_d;
  logic signed [icpid_pkg::NXT_W-1:0] max_ext, min_ext;
  logic [icpid_pkg::POS_W-1:0]        drive_d;

  // Handshakes. A stage loads when it is empty or the stage after it loads.
  assign cfg_i.ready = 1'b1;
  assign load_out    = !out_valid_q || drive_o.ready;

  always_comb begin
    load[NUM_STG-1] = !vld_q[NUM_STG-1] || load_out;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
  end

  assign meas_i.ready      = load[0];
  assign drive_o.valid     = out_valid_q;
  assign drive_o.drive_value = drive_q;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= '0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      drive_max_q <= icpid_pkg::DRIVE_MAX_RESET;
      drive_min_q <= icpid_pkg::DRIVE_MIN_RESET;
    end else if (cfg_i.valid) begin
      unique case (icpid_pkg::cfg_reg_e'(cfg_i.index))
        icpid_pkg::REG_SETPOINT:  setpoint_q  <= cfg_i.data;
        icpid_pkg::REG_GAIN_P:    gain_p_q    <= cfg_i.data;
        icpid_pkg::REG_GAIN_I:    gain_i_q    <= cfg_i.data;
        icpid_pkg::REG_GAIN_D:    gain_d_q    <= cfg_i.data;
        icpid_pkg::REG_DRIVE_MAX: drive_max_q <= cfg_i.data;
        icpid_pkg::REG_DRIVE_MIN: drive_min_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Error stage: the error and both differences fit their widths exactly, so
  // two's complement wrap in the intermediate terms does no harm.
  always_comb begin
    err_d = $signed({2'b00, setpoint_q}) - $signed({2'b00, meas0_q});
    dp_d  = err_d - last_err_q;
    dd_d  = {err_d[icpid_pkg::ERR_W-1], err_d}
          - {last_err_q, 1'b0}
          + {prior_err_q[icpid_pkg::ERR_W-1], prior_err_q};
  end

  // Product stage: three independent multiplies, gains taken as positive.
  always_comb begin
    prod_p_d = $signed({1'b0, gain_p_q}) * dp1_q;
    prod_i_d = $signed({1'b0, gain_i_q}) * err1_q;
    prod_d_d = $signed({1'b0, gain_d_q}) * dd1_q;
  end

  // Sum stage: add the products and split into sign and magnitude so the
  // divide below works on an unsigned value and truncates toward zero.
  always_comb begin
    sum_d = prod_p2_q + prod_i2_q + prod_d2_q;
    if (sum_d[icpid_pkg::SUM_W-1]) begin
      mag_d = icpid_pkg::MAG_W'(-sum_d);
    end else begin
      mag_d = sum_d[icpid_pkg::MAG_W-1:0];
    end
  end

  // Divide split stage: high part by a constant multiply, low part by the
  // reciprocal of ten, which is exact for any 32-bit dividend.
  always_comb begin
    xh         = mag3_q[icpid_pkg::MAG_W-1:icpid_pkg::SPLIT_W];
    xl         = mag3_q[icpid_pkg::SPLIT_W-1:0];
    hi_d       = {{(icpid_pkg::QUO_W - icpid_pkg::XH_W){1'b0}}, xh} * icpid_pkg::DIV_HI_MUL;
    low_d      = icpid_pkg::LOW_W'(xh) * icpid_pkg::DIV_LO_MUL + icpid_pkg::LOW_W'(xl);
    recip_prod = {{(64 - icpid_pkg::LOW_W){1'b0}}, low_d} * {32'd0, icpid_pkg::RECIP_10};
  end

  // Increment stage: join the quotient halves and restore the sign.
  always_comb begin
    quo_d = hi4_q + icpid_pkg::QUO_W'(qlo4_q);
    if (neg4_q) begin
      inc_d = -$signed({1'b0, quo_d});
    end else begin
      inc_d = $signed({1'b0, quo_d});
    end
  end

  // Output stage: accumulate and clamp. The minimum has priority over the
  // maximum, so when the limits cross the drive takes the minimum.
  always_comb begin
    next_d  = $signed({{(icpid_pkg::NXT_W - icpid_pkg::POS_W){1'b0}}, drive_q})
            + {inc5_q[icpid_pkg::INC_W-1], inc5_q};
    max_ext = $signed({{(icpid_pkg::NXT_W - icpid_pkg::POS_W){1'b0}}, drive_max_q});
    min_ext = $signed({{(icpid_pkg::NXT_W - icpid_pkg::POS_W){1'b0}}, drive_min_q});
    priority if (next_d < min_ext || max_ext < min_ext) begin
      drive_d = drive_min_q;
    end else if (next_d > max_ext) begin
      drive_d = drive_max_q;
    end else begin
      drive_d = next_d[icpid_pkg::POS_W-1:0];
    end
  end

  // Control state: stage valids, error history, drive level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      last_err_q  <= '0;
      prior_err_q <= '0;
      drive_q     <= '0;
    end else begin
      if (load[0]) begin
        vld_q[0] <= meas_i.valid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (load[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (load_out) begin
        out_valid_q <= vld_q[NUM_STG-1];
      end
      // The history moves in request order as each item leaves the error stage.
      if (load[1] && vld_q[0]) begin
        last_err_q  <= err_d;
        prior_err_q <= last_err_q;
      end
      if (load_out && vld_q[NUM_STG-1]) begin
        drive_q <= drive_d;
      end
    end
  end

  // Stage payloads need no reset.
  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      meas0_q <= meas_i.measured_position;
    end
    if (load[1]) begin
      err1_q <= err_d;
      dp1_q  <= dp_d;
      dd1_q  <= dd_d;
    end
    if (load[2]) begin
      prod_p2_q <= {prod_p_d[34], prod_p_d};
      prod_i2_q <= {prod_i_d[34], prod_i_d};
      prod_d2_q <= prod_d_d;
    end
    if (load[3]) begin
      mag3_q <= mag_d;
      neg3_q <= sum_d[icpid_pkg::SUM_W-1];
    end
    if (load[4]) begin
      hi4_q  <= hi_d;
      qlo4_q <= recip_prod[icpid_pkg::RECIP_SHIFT +: icpid_pkg::QLO_W];
      neg4_q <= neg3_q;
    end
    if (load[5]) begin
      inc5_q <= inc_d;
    end
  end

endmodule

// ===== rtl/icpid_checker.sv =====
// Port-level assertions for the PID block and the bind that attaches them.
module icpid_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [icpid_pkg::POS_W-1:0] out_value_i,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_i
);

  // A drive request that is held off stays up.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("drive request dropped while stalled");

  // A held-off drive keeps its value.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i))
    else $error("drive value changed while stalled");

  // Register writes are never stalled.
  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

  // Reset empties the output, and no drive can appear right as reset ends.
  a_reset_empty : assert property (@(posedge clk_i)
    !rst_ni || $rose(rst_ni) |-> !out_valid_i)
    else $error("drive request present during or right after reset");

endmodule

bind incremental_pid_clamped icpid_checker u_icpid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (drive_o.valid),
  .out_ready_i (drive_o.ready),
  .out_value_i (drive_o.drive_value),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);
